// ----- rtl/lcdlt_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, timing constants, mode codes and stage payload types for the LCD line timing block.
package lcdlt_pkg;

	// Field and state widths.
	localparam int unsigned FC_W   = 15;
	localparam int unsigned COL_W  = 7;
	localparam int unsigned LINE_W = 8;
	localparam int unsigned CNT_W  = 8;

	// Default frame and line lengths in machine clocks.
	localparam int unsigned FRAME_CLOCKS_DEF = 17556;
	localparam int unsigned LINE_CLOCKS_DEF  = 114;

	// Line and column boundaries of the display modes.
	localparam logic [LINE_W-1:0] VBLANK_LINE  = 8'd145;
	localparam logic [LINE_W-1:0] LAST_VISIBLE = 8'd144;
	localparam logic [COL_W-1:0]  OAM_END      = 7'd21;
	localparam logic [COL_W-1:0]  XFER_END     = 7'd64;

	// Display mode codes as they appear on the mode output.
	typedef enum logic [1:0] {
		MODE_VBLANK = 2'd0,
		MODE_OAM    = 2'd1,
		MODE_XFER   = 2'd2,
		MODE_HBLANK = 2'd3
	} lcd_mode_t;

	// One tick after the frame counter stage.
	typedef struct packed {
		logic            on;       // display enabled on this tick
		logic            black;    // display turned off with a running counter
		logic            fc_zero;  // counter was zero before this tick
		logic [FC_W-1:0] fc;       // frame clock after this tick
	} tick_t;

endpackage

// ----- rtl/lcdlt_frame_counter.sv -----
`timescale 1ns / 1ps
// First stage: frame clock counter with wrap, display-off clear and tick register.
module lcdlt_frame_counter import lcdlt_pkg::*; #(
	parameter int unsigned FRAME_CLOCKS = FRAME_CLOCKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             lcd_enable,
	input  logic [CNT_W-1:0] clock_count,
	output logic             tick_valid,
	input  logic             tick_stall,
	output tick_t            tick
);

	logic [FC_W-1:0] fc_q;
	logic            valid_s1;
	tick_t           tick_s1;
	logic            take;
	logic [FC_W:0]   sum;
	logic [FC_W:0]   wrapped;
	logic [FC_W-1:0] fc_next;
	tick_t           tick_next;

	// The stage holds while its beat waits downstream.
	assign in_stall = valid_s1 && tick_stall;
	assign take     = in_valid && !in_stall;

	// Advance the counter and wrap once at the frame length.
	always_comb begin
		sum     = {1'b0, fc_q} + (FC_W+1)'(clock_count);
		wrapped = sum - (FC_W+1)'(FRAME_CLOCKS);
		if (sum >= (FC_W+1)'(FRAME_CLOCKS)) begin
			fc_next = wrapped[FC_W-1:0];
		end else begin
			fc_next = sum[FC_W-1:0];
		end
		tick_next.on      = lcd_enable;
		tick_next.black   = !lcd_enable && (fc_q != '0);
		tick_next.fc_zero = (fc_q == '0);
		tick_next.fc      = lcd_enable ? fc_next : '0;
	end

	// Counter state; turning the display off always leaves it at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= '0;
		end else if (take) begin
			fc_q <= tick_next.fc;
		end
	end

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			tick_s1 <= tick_next;
		end
	end

	assign tick_valid = valid_s1;
	assign tick       = tick_s1;

	// The counter never reaches the frame length.
	a_fc_range: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q < FC_W'(FRAME_CLOCKS))
		else $error("frame clock out of range");

	// A beat with the display off leaves the counter cleared.
	a_off_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && !lcd_enable |=> fc_q == '0)
		else $error("frame clock not cleared by display off");

endmodule

// ----- rtl/lcdlt_line_divide.sv -----
`timescale 1ns / 1ps
// Second stage: line index as frame clock divided by the line length, by reciprocal multiply.
module lcdlt_line_divide import lcdlt_pkg::*; #(
	parameter int unsigned LINE_CLOCKS = LINE_CLOCKS_DEF,
	parameter int unsigned QUO_W = $clog2(((2 ** FC_W) - 1) / LINE_CLOCKS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick_valid,
	output logic             tick_stall,
	input  tick_t            tick,
	output logic             div_valid,
	input  logic             div_stall,
	output tick_t            div_tick,
	output logic [QUO_W-1:0] quo
);

	// With a line length below 2**COL_W and a counter of FC_W bits, this
	// rounded-up reciprocal gives the exact quotient for every counter value.
	localparam int unsigned RECIP_SHIFT = FC_W + COL_W;
	localparam int unsigned RECIP = ((2 ** RECIP_SHIFT) + LINE_CLOCKS - 1) / LINE_CLOCKS;
	localparam int unsigned RECIP_W = $clog2(RECIP + 1);
	localparam int unsigned PROD_W = FC_W + RECIP_W;

	logic              valid_s2;
	tick_t             tick_s2;
	logic [QUO_W-1:0]  quo_s2;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_sh;

	assign tick_stall = valid_s2 && div_stall;

	// Multiply by the reciprocal and keep the integer part.
	always_comb begin
		prod    = PROD_W'(tick.fc) * PROD_W'(RECIP);
		prod_sh = prod >> RECIP_SHIFT;
	end

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!tick_stall) begin
			valid_s2 <= tick_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s2 <= tick;
			quo_s2  <= QUO_W'(prod_sh);
		end
	end

	assign div_valid = valid_s2;
	assign div_tick  = tick_s2;
	assign quo       = quo_s2;

endmodule

// ----- rtl/lcdlt_line_decode.sv -----
`timescale 1ns / 1ps
// Third stage: column, line number, mode and pulses, with last-line state and the result register.
module lcdlt_line_decode import lcdlt_pkg::*; #(
	parameter int unsigned LINE_CLOCKS = LINE_CLOCKS_DEF,
	parameter int unsigned QUO_W = $clog2(((2 ** FC_W) - 1) / LINE_CLOCKS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              div_valid,
	output logic              div_stall,
	input  tick_t             div_tick,
	input  logic [QUO_W-1:0]  quo,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              line_written,
	output logic [LINE_W-1:0] line_number,
	output logic [1:0]        lcd_mode,
	output logic              vblank_pulse,
	output logic              render_pulse,
	output logic              blank_black_pulse,
	output logic              fill_white_pulse
);

	logic              valid_q;
	logic [COL_W-1:0]  last_col_q;
	logic [LINE_W-1:0] last_line_q;
	logic              written_q;
	logic [LINE_W-1:0] line_q;
	lcd_mode_t         mode_q;
	logic              vblank_q;
	logic              render_q;
	logic              black_q;
	logic              white_q;

	logic              take;
	logic [FC_W-1:0]   quo_times;
	logic [FC_W-1:0]   col_full;
	logic [COL_W-1:0]  column;
	logic [QUO_W:0]    line_full;
	logic [LINE_W-1:0] line;
	lcd_mode_t         mode;
	logic              vblank;
	logic              render;
	logic              white;

	assign div_stall = valid_q && out_stall;
	assign take      = div_valid && !div_stall;

	// Column is the remainder left after the whole lines; lines count from one.
	always_comb begin
		quo_times = FC_W'(quo) * FC_W'(LINE_CLOCKS);
		col_full  = div_tick.fc - quo_times;
		column    = col_full[COL_W-1:0];
		line_full = {1'b0, quo} + (QUO_W+1)'(1);
		line      = LINE_W'(line_full);
	end

	// Mode from line first, then from column.
	always_comb begin
		priority if (line >= VBLANK_LINE) begin
			mode = MODE_VBLANK;
		end else if (column < OAM_END) begin
			mode = MODE_OAM;
		end else if (column < XFER_END) begin
			mode = MODE_XFER;
		end else begin
			mode = MODE_HBLANK;
		end
	end

	// Pulses against the line of the previous display-on beat.
	always_comb begin
		vblank = div_tick.on && (line >= VBLANK_LINE) && (last_line_q <= LAST_VISIBLE);
		render = div_tick.on && (last_line_q > LAST_VISIBLE) && (line < LAST_VISIBLE);
		white  = div_tick.on && div_tick.fc_zero && (last_line_q == '0) && (last_col_q == '0);
	end

	// Last column and line follow display-on beats and clear with the black pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q  <= '0;
			last_line_q <= '0;
		end else if (take) begin
			if (div_tick.on) begin
				last_col_q  <= column;
				last_line_q <= line;
			end else if (div_tick.black) begin
				last_col_q  <= '0;
				last_line_q <= '0;
			end
		end
	end

	// Result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!div_stall) begin
			valid_q <= div_valid;
		end
	end

	// Result payload; a display-off beat gives zeros except the black pulse.
	always_ff @(posedge clk) begin
		if (take) begin
			written_q <= div_tick.on;
			line_q    <= div_tick.on ? line : '0;
			mode_q    <= div_tick.on ? mode : MODE_VBLANK;
			vblank_q  <= vblank;
			render_q  <= render;
			black_q   <= div_tick.black;
			white_q   <= white;
		end
	end

	assign out_valid         = valid_q;
	assign line_written      = written_q;
	assign line_number       = line_q;
	assign lcd_mode          = mode_q;
	assign vblank_pulse      = vblank_q;
	assign render_pulse      = render_q;
	assign blank_black_pulse = black_q;
	assign fill_white_pulse  = white_q;

	// A display-off result carries no line number.
	a_off_no_line: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !written_q |-> line_q == '0 && !vblank_q && !render_q && !white_q)
		else $error("display-off result carries line data");

	// Black and white fills never come together.
	a_fill_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> !(black_q && white_q))
		else $error("black and white fill in one beat");

	// Entering vblank reports the vblank mode.
	a_vblank_mode: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && vblank_q |-> mode_q == MODE_VBLANK && line_q >= VBLANK_LINE)
		else $error("vblank pulse without vblank mode");

endmodule

// ----- rtl/lcd_line_timing.sv -----
`timescale 1ns / 1ps
// Top level of the LCD line timing block.
//
// Each input beat is one tick with the display enable bit and the machine clocks
// elapsed since the previous tick; each gives exactly one result beat. The block
// takes one beat per clock while no stage is held by a stall. The three register
// stages are the frame clock counter with its wrap, a reciprocal multiply that
// yields the line index, and a decode stage that forms column, line number, mode
// and pulses into the result register. The frame clock update and the last column
// and line kept for the pulses are the only state carried from beat to beat. Each
// stage holds while the stage after it is full and stalled.
module lcd_line_timing import lcdlt_pkg::*; #(
	parameter int unsigned FRAME_CLOCKS = FRAME_CLOCKS_DEF,
	parameter int unsigned LINE_CLOCKS  = LINE_CLOCKS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              lcd_enable,
	input  logic [CNT_W-1:0]  clock_count,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              line_written,
	output logic [LINE_W-1:0] line_number,
	output logic [1:0]        lcd_mode,
	output logic              vblank_pulse,
	output logic              render_pulse,
	output logic              blank_black_pulse,
	output logic              fill_white_pulse
);

	localparam int unsigned QUO_W = $clog2(((2 ** FC_W) - 1) / LINE_CLOCKS + 1);

	logic             tick_valid;
	logic             tick_stall;
	tick_t            tick;
	logic             div_valid;
	logic             div_stall;
	tick_t            div_tick;
	logic [QUO_W-1:0] quo;

	// Frame clock counter.
	lcdlt_frame_counter #(
		.FRAME_CLOCKS (FRAME_CLOCKS)
	) u_counter (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.lcd_enable  (lcd_enable),
		.clock_count (clock_count),
		.tick_valid  (tick_valid),
		.tick_stall  (tick_stall),
		.tick        (tick)
	);

	// Line index.
	lcdlt_line_divide #(
		.LINE_CLOCKS (LINE_CLOCKS),
		.QUO_W       (QUO_W)
	) u_divide (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.tick       (tick),
		.div_valid  (div_valid),
		.div_stall  (div_stall),
		.div_tick   (div_tick),
		.quo        (quo)
	);

	// Column, mode, pulses and result register.
	lcdlt_line_decode #(
		.LINE_CLOCKS (LINE_CLOCKS),
		.QUO_W       (QUO_W)
	) u_decode (
		.clk               (clk),
		.arst_n            (arst_n),
		.div_valid         (div_valid),
		.div_stall         (div_stall),
		.div_tick          (div_tick),
		.quo               (quo),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.line_written      (line_written),
		.line_number       (line_number),
		.lcd_mode          (lcd_mode),
		.vblank_pulse      (vblank_pulse),
		.render_pulse      (render_pulse),
		.blank_black_pulse (blank_black_pulse),
		.fill_white_pulse  (fill_white_pulse)
	);

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the LCD line timing block with a tick-level timing predictor.
module tb;
	import lcdlt_pkg::*;

	localparam int unsigned FRAME_CLKS   = FRAME_CLOCKS_DEF;
	localparam int unsigned LINE_CLKS    = LINE_CLOCKS_DEF;
	localparam int unsigned RANDOM_TICKS = 1500;
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned MAX_REPORTS  = 30;
	localparam int unsigned LIMIT_NS     = 5_000_000;

	// One result beat as seen on the output ports.
	typedef struct packed {
		logic              written;
		logic [LINE_W-1:0] line;
		lcd_mode_t         mode;
		logic              vblank;
		logic              render;
		logic              black;
		logic              white;
	} lcd_result_t;

	// Tracks the frame clock, column and line, and holds the results still owed by the block.
	class lcd_timing_board;
		logic [FC_W-1:0]   frame_clock;
		logic [COL_W-1:0]  column;
		logic [LINE_W-1:0] line;
		lcd_result_t       due[$];
		int unsigned       errors, checked, ticks;
		int unsigned       vblanks, renders, blacks, whites, exact_wraps;

		function new();
			frame_clock = '0;
			column      = '0;
			line        = '0;
			errors      = 0;
			checked     = 0;
			ticks       = 0;
			vblanks     = 0;
			renders     = 0;
			blacks      = 0;
			whites      = 0;
			exact_wraps = 0;
		endfunction

		// Advance the timing state by one accepted tick and queue the result it causes.
		function void note_tick(logic en, logic [CNT_W-1:0] cnt);
			lcd_result_t       r;
			int unsigned       sum;
			logic [COL_W-1:0]  col_next;
			logic [LINE_W-1:0] line_next;
			r = '0;
			ticks++;
			if (!en) begin
				// Turning the display off only matters while the frame counter runs.
				if (frame_clock != 0) begin
					frame_clock = '0;
					column      = '0;
					line        = '0;
					r.black     = 1'b1;
					blacks++;
				end
			end else begin
				r.white = (frame_clock == 0 && column == 0 && line == 0);
				sum = frame_clock + cnt;
				if (sum >= FRAME_CLKS) begin
					if (sum == FRAME_CLKS)
						exact_wraps++;
					sum -= FRAME_CLKS;
				end
				frame_clock = FC_W'(sum);
				col_next    = COL_W'(frame_clock % LINE_CLKS);
				line_next   = LINE_W'(frame_clock / LINE_CLKS + 1);

				// Vblank wins over the column-based modes.
				if (line_next >= VBLANK_LINE)
					r.mode = MODE_VBLANK;
				else if (col_next < OAM_END)
					r.mode = MODE_OAM;
				else if (col_next < XFER_END)
					r.mode = MODE_XFER;
				else
					r.mode = MODE_HBLANK;

				r.written = 1'b1;
				r.line    = line_next;
				r.vblank  = (line_next >= VBLANK_LINE && line <= LAST_VISIBLE);
				r.render  = (line > LAST_VISIBLE && line_next < LAST_VISIBLE);
				column    = col_next;
				line      = line_next;
				if (r.white)
					whites++;
				if (r.vblank)
					vblanks++;
				if (r.render)
					renders++;
			end
			due.push_back(r);
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		task compare_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
					checked, name, got, want));
		endtask

		// Compare one accepted result beat with the oldest expected result.
		task check_result(lcd_result_t got);
			lcd_result_t want;
			if (due.size() == 0) begin
				report_mismatch("result beat with no tick waiting");
				return;
			end
			want = due.pop_front();
			checked++;
			compare_field("line_written", got.written, want.written);
			compare_field("line_number", got.line, want.line);
			compare_field("lcd_mode", got.mode, want.mode);
			compare_field("vblank_pulse", got.vblank, want.vblank);
			compare_field("render_pulse", got.render, want.render);
			compare_field("blank_black_pulse", got.black, want.black);
			compare_field("fill_white_pulse", got.white, want.white);
		endtask
	endclass

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic              lcd_enable  = 1'b0;
	logic [CNT_W-1:0]  clock_count = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic              line_written;
	logic [LINE_W-1:0] line_number;
	logic [1:0]        lcd_mode;
	logic              vblank_pulse;
	logic              render_pulse;
	logic              blank_black_pulse;
	logic              fill_white_pulse;

	int unsigned       send_idle_pct  = 0;
	int unsigned       recv_stall_pct = 0;
	bit                hold_req       = 1'b0;
	int unsigned       run_left       = 0;
	int unsigned       off_left       = 0;

	lcd_timing_board   sb = new();

	lcd_line_timing #(
		.FRAME_CLOCKS(FRAME_CLKS),
		.LINE_CLOCKS (LINE_CLKS)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.lcd_enable       (lcd_enable),
		.clock_count      (clock_count),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.line_written     (line_written),
		.line_number      (line_number),
		.lcd_mode         (lcd_mode),
		.vblank_pulse     (vblank_pulse),
		.render_pulse     (render_pulse),
		.blank_black_pulse(blank_black_pulse),
		.fill_white_pulse (fill_white_pulse)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one tick, with random idle cycles first, and wait until it is taken.
	task automatic send_tick(input logic en, input logic [CNT_W-1:0] cnt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		lcd_enable  <= en;
		clock_count <= cnt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_tick(en, cnt);
	endtask

	// Random ticks come in long display-on runs separated by short off bursts,
	// so that frames run through vblank and wrap around.
	task automatic send_random_tick();
		logic [CNT_W-1:0] cnt;
		int unsigned      room;
		if (off_left == 0 && run_left == 0) begin
			off_left = $urandom_range(1, 3);
			run_left = ($urandom_range(3) == 0) ? $urandom_range(1, 20) : $urandom_range(100, 400);
		end
		if (off_left > 0) begin
			off_left--;
			send_tick(1'b0, CNT_W'($urandom_range(255)));
		end else begin
			room = FRAME_CLKS - sb.frame_clock;
			// Near the end of a frame, often land exactly on the frame start.
			if (room <= 255 && $urandom_range(2) == 0)
				cnt = CNT_W'(room);
			else begin
				case ($urandom_range(9))
					0:       cnt = '1;
					1:       cnt = CNT_W'($urandom_range(3));
					default: cnt = CNT_W'($urandom_range(255));
				endcase
			end
			run_left--;
			send_tick(1'b1, cnt);
			// After an exact wrap the counter reads zero; often switch off right there.
			if (sb.frame_clock == 0 && sb.line != 0 && $urandom_range(1) == 0)
				run_left = 0;
		end
	endtask

	// Result side: check accepted beats and drive the output stall.
	initial begin
		lcd_result_t got;
		int unsigned hold_cnt;
		hold_cnt = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.written = line_written;
				got.line    = line_number;
				got.mode    = lcd_mode_t'(lcd_mode);
				got.vblank  = vblank_pulse;
				got.render  = render_pulse;
				got.black   = blank_black_pulse;
				got.white   = fill_white_pulse;
				sb.check_result(got);
			end
			// A requested hold-off stalls the output long enough to back up the pipeline.
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Stimulus: reset, directed ticks, then random ticks over the idling phases.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Off straight after reset does nothing; first on from zero fills white.
		send_tick(1'b0, 8'd0);
		send_tick(1'b1, 8'd0);
		// A second zero tick must not fill white again, since the line is now one.
		send_tick(1'b1, 8'd0);
		// Off with a zero counter keeps the state and gives no black pulse.
		send_tick(1'b0, 8'd255);
		// Walk the column across the mode boundaries and into the second line.
		send_tick(1'b1, 8'd20);
		send_tick(1'b1, 8'd1);
		send_tick(1'b1, 8'd42);
		send_tick(1'b1, 8'd1);
		send_tick(1'b1, 8'd49);
		send_tick(1'b1, 8'd1);
		send_tick(1'b1, 8'd255);
		// Off with a running counter blanks to black; a second off does nothing.
		send_tick(1'b0, 8'd255);
		send_tick(1'b0, 8'd0);
		// Back on from cleared state fills white again.
		send_tick(1'b1, 8'd255);
		send_tick(1'b1, 8'd0);
		send_tick(1'b1, 8'd128);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					hold_req       = 1'b1;
				end
				1: begin
					send_idle_pct  = 71;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 71;
				end
				default: begin
					send_idle_pct  = 26;
					recv_stall_pct = 26;
				end
			endcase
			repeat (RANDOM_TICKS / 4)
				send_random_tick();
		end
		in_valid <= 1'b0;

		// Drain the pipeline, then watch a little longer for stray beats.
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.due.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.due.size()));

		$display("Ran %0d ticks, checked %0d results across four idling phases and a %0d-cycle hold-off.",
			sb.ticks, sb.checked, HOLD_CYCLES);
		$display("Pulses seen: vblank %0d, render %0d, black %0d, white %0d; exact frame wraps %0d.",
			sb.vblanks, sb.renders, sb.blacks, sb.whites, sb.exact_wraps);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule
